FILE: hw/rtl/supersample_image_scaler_core_macros.svh
// Assertion macros used by the scaler datapath.
`ifndef SUPERSAMPLE_IMAGE_SCALER_CORE_MACROS_SVH
`define SUPERSAMPLE_IMAGE_SCALER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset
`define SSIS_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define SSIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ssis_pkg.sv
// Shared types, constants and register indexes of the supersampling scaler.
package ssis_pkg;

	// Default sizing of the source store and the sample grid
	localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
	localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
	localparam int unsigned DEF_MAX_SAMPLES    = 8;

	// Field widths
	localparam int unsigned COLOR_W    = 8;
	localparam int unsigned COORD_W    = 8;
	localparam int unsigned DEST_W     = 12;
	localparam int unsigned DIM_W      = 9;
	localparam int unsigned SAMP_W     = 4;
	localparam int unsigned STEP_W     = 25;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 25;

	// 22.16 positions: 12-bit coordinate times 25-bit step plus up to 16 substeps
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned POS_W     = 38;
	localparam int unsigned IDX_W     = POS_W - FRAC_BITS;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSTEP_X  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSTEP_Y  = 3'd6;

	// Register reset values
	localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 9'd256;
	localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 9'd256;
	localparam logic [SAMP_W-1:0] RST_SAMPLES    = 4'd2;
	localparam logic [STEP_W-1:0] RST_STEP       = 25'd65536;
	localparam logic [STEP_W-1:0] RST_SUBSTEP    = 25'd32768;

	// Operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_DRAIN,
		ST_DIVIDE
	} ssis_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_wr;
		logic start;
		logic issue;
		logic div_start;
		logic out_load;
	} ssis_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_sample;
		logic pipe_busy;
		logic div_done;
		logic out_blocked;
	} ssis_status_t;

endpackage

FILE: hw/rtl/ssis_ctrl.sv
// Sequencing state machine of the scaler: loads, sample sweep, drain, divide.
module ssis_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  op,
	output logic                  in_stall,
	input  ssis_pkg::ssis_status_t status,
	output ssis_pkg::ssis_cmd_t    cmd
);
	import ssis_pkg::*;

	ssis_state_t state_q;
	ssis_state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op == OP_REQUEST) begin
						cmd.start  = 1'b1;
						state_next = ST_SAMPLE;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_SAMPLE: begin
				// one memory read per cycle over the grid
				cmd.issue = 1'b1;
				if (status.last_sample) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_done && !status.out_blocked) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/ssis_datapath.sv
// Scaler datapath: registers, image memory, sample addressing, sums, divider, output.
`include "supersample_image_scaler_core_macros.svh"

module ssis_datapath #(
	parameter int unsigned MAX_SRC_WIDTH  = ssis_pkg::DEF_MAX_SRC_WIDTH,
	parameter int unsigned MAX_SRC_HEIGHT = ssis_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int unsigned MAX_SAMPLES    = ssis_pkg::DEF_MAX_SAMPLES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssis_pkg::ssis_cmd_t                  cmd,
	output ssis_pkg::ssis_status_t               status,
	input  logic                                cfg_we,
	input  logic [ssis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssis_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [ssis_pkg::COORD_W-1:0]        load_x,
	input  logic [ssis_pkg::COORD_W-1:0]        load_y,
	input  logic [ssis_pkg::COLOR_W-1:0]        load_red,
	input  logic [ssis_pkg::COLOR_W-1:0]        load_green,
	input  logic [ssis_pkg::COLOR_W-1:0]        load_blue,
	input  logic [ssis_pkg::DEST_W-1:0]         dest_u,
	input  logic [ssis_pkg::DEST_W-1:0]         dest_v,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [ssis_pkg::COLOR_W-1:0]        out_red,
	output logic [ssis_pkg::COLOR_W-1:0]        out_green,
	output logic [ssis_pkg::COLOR_W-1:0]        out_blue
);
	import ssis_pkg::*;

	localparam int unsigned CW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int unsigned RW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned WW    = $clog2(MAX_SRC_WIDTH + 1);
	localparam int unsigned HW    = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int unsigned NW    = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned JW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned DVW   = $clog2(MAX_SAMPLES * MAX_SAMPLES + 1);
	localparam int unsigned CMAX  = (1 << COLOR_W) - 1;
	localparam int unsigned SW    = $clog2(MAX_SAMPLES * MAX_SAMPLES * CMAX + 1);
	localparam int unsigned DCW   = $clog2(SW + 1);
	localparam int unsigned PXW   = 3 * COLOR_W;
	localparam int unsigned NCH   = 3;

	// Clamp a size register to 1..hi
	function automatic logic [31:0] clamp_cfg(logic [31:0] v, logic [31:0] hi);
		logic [31:0] r;
		r = v;
		if (v == 32'd0) begin
			r = 32'd1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Configuration registers
	logic [DIM_W-1:0]  width_cfg_q;
	logic [DIM_W-1:0]  height_cfg_q;
	logic [SAMP_W-1:0] samples_cfg_q;
	logic [STEP_W-1:0] step_x_q;
	logic [STEP_W-1:0] step_y_q;
	logic [STEP_W-1:0] substep_x_q;
	logic [STEP_W-1:0] substep_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q   <= RST_SRC_WIDTH;
			height_cfg_q  <= RST_SRC_HEIGHT;
			samples_cfg_q <= RST_SAMPLES;
			step_x_q      <= RST_STEP;
			step_y_q      <= RST_STEP;
			substep_x_q   <= RST_SUBSTEP;
			substep_y_q   <= RST_SUBSTEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  width_cfg_q   <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT: height_cfg_q  <= cfg_data[DIM_W-1:0];
				REG_SAMPLES:    samples_cfg_q <= cfg_data[SAMP_W-1:0];
				REG_STEP_X:     step_x_q      <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:     step_y_q      <= cfg_data[STEP_W-1:0];
				REG_SUBSTEP_X:  substep_x_q   <= cfg_data[STEP_W-1:0];
				REG_SUBSTEP_Y:  substep_y_q   <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamped sizes and divisor, latched at request start
	logic [WW-1:0]                w_clamp;
	logic [HW-1:0]                h_clamp;
	logic [NW-1:0]                n_clamp;
	logic [DEST_W+STEP_W-1:0]     prod_x;
	logic [DEST_W+STEP_W-1:0]     prod_y;

	assign w_clamp = WW'(clamp_cfg(32'(width_cfg_q), 32'(MAX_SRC_WIDTH)));
	assign h_clamp = HW'(clamp_cfg(32'(height_cfg_q), 32'(MAX_SRC_HEIGHT)));
	assign n_clamp = NW'(clamp_cfg(32'(samples_cfg_q), 32'(MAX_SAMPLES)));
	assign prod_x  = dest_u * step_x_q;
	assign prod_y  = dest_v * step_y_q;

	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic [NW-1:0]    n_q;
	logic [DVW-1:0]   div_q;
	logic [POS_W-1:0] base_x_q;
	logic [POS_W-1:0] pos_x_q;
	logic [POS_W-1:0] pos_y_q;
	logic [JW-1:0]    j_q;
	logic [JW-1:0]    i_q;

	// Grid position tracking
	logic [IDX_W-1:0] col_idx;
	logic [IDX_W-1:0] row_idx;
	logic [CW-1:0]    col;
	logic [RW-1:0]    row;
	logic [AW-1:0]    rd_addr;
	logic             col_last;
	logic             row_last;

	assign col_idx  = pos_x_q[POS_W-1:FRAC_BITS];
	assign row_idx  = pos_y_q[POS_W-1:FRAC_BITS];
	assign col      = (col_idx >= IDX_W'(w_q)) ? CW'(w_q - 1'b1) : CW'(col_idx);
	assign row      = (row_idx >= IDX_W'(h_q)) ? RW'(h_q - 1'b1) : RW'(row_idx);
	assign rd_addr  = AW'(row) * AW'(MAX_SRC_WIDTH) + AW'(col);
	assign col_last = (NW'(j_q) == n_q - NW'(1));
	assign row_last = (NW'(i_q) == n_q - NW'(1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			w_q      <= w_clamp;
			h_q      <= h_clamp;
			n_q      <= n_clamp;
			div_q    <= DVW'(n_clamp) * DVW'(n_clamp);
			base_x_q <= POS_W'(prod_x);
			pos_x_q  <= POS_W'(prod_x);
			pos_y_q  <= POS_W'(prod_y);
		end else if (cmd.issue) begin
			if (col_last) begin
				pos_x_q <= base_x_q;
				pos_y_q <= pos_y_q + POS_W'(substep_y_q);
			end else begin
				pos_x_q <= pos_x_q + POS_W'(substep_x_q);
			end
		end
	end

	// Grid counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			i_q <= '0;
		end else if (cmd.start) begin
			j_q <= '0;
			i_q <= '0;
		end else if (cmd.issue) begin
			if (col_last) begin
				j_q <= '0;
				i_q <= i_q + JW'(1);
			end else begin
				j_q <= j_q + JW'(1);
			end
		end
	end

	// Read pipeline valid bits
	logic          v_s1_q;
	logic          v_s2_q;
	logic [AW-1:0] addr_s1;
	logic [PXW-1:0] rd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= cmd.issue;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			addr_s1 <= rd_addr;
		end
	end

	// Source image memory: one write port for loads, one registered read port
	logic [PXW-1:0] image_mem [DEPTH];
	logic           wr_ok;
	logic [AW-1:0]  wr_addr;

	assign wr_ok   = (32'(load_x) < MAX_SRC_WIDTH) && (32'(load_y) < MAX_SRC_HEIGHT);
	assign wr_addr = AW'(load_y) * AW'(MAX_SRC_WIDTH) + AW'(load_x);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			image_mem[wr_addr] <= {load_red, load_green, load_blue};
		end
		rd_s2 <= image_mem[addr_s1];
	end

	// Per-channel sums; channel 0 red, 1 green, 2 blue
	logic [SW-1:0] acc_q [NCH];

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (cmd.start) begin
				acc_q[c] <= '0;
			end else if (v_s2_q) begin
				acc_q[c] <= acc_q[c] + SW'(rd_s2[(NCH-1-c)*COLOR_W +: COLOR_W]);
			end
		end
	end

	// Restoring divider, one quotient bit per cycle on all channels
	logic [SW-1:0]  quo_q [NCH];
	logic [DVW-1:0] rem_q [NCH];
	logic [DVW:0]   trial [NCH];
	logic           ge    [NCH];
	logic [DCW-1:0] div_cnt_q;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			trial[c] = {rem_q[c], quo_q[c][SW-1]};
			ge[c]    = (trial[c] >= {1'b0, div_q});
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (cmd.div_start) begin
				quo_q[c] <= acc_q[c];
				rem_q[c] <= '0;
			end else if (div_cnt_q != '0) begin
				quo_q[c] <= {quo_q[c][SW-2:0], ge[c]};
				rem_q[c] <= ge[c] ? DVW'(trial[c] - {1'b0, div_q}) : trial[c][DVW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DCW'(SW);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// Output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_red_q;
	logic [COLOR_W-1:0] out_green_q;
	logic [COLOR_W-1:0] out_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_red_q   <= quo_q[0][COLOR_W-1:0];
			out_green_q <= quo_q[1][COLOR_W-1:0];
			out_blue_q  <= quo_q[2][COLOR_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;

	// Status
	assign status.last_sample = col_last && row_last;
	assign status.pipe_busy   = v_s1_q || v_s2_q;
	assign status.div_done    = (div_cnt_q == '0);
	assign status.out_blocked = out_valid_q && out_stall;

	// Checks
	`SSIS_ASSERT_HOLDS(a_div_pipe_idle, div_cnt_q != '0, !v_s1_q && !v_s2_q, "read pipe active during divide")
	`SSIS_ASSERT_HOLDS(a_start_clean, cmd.start, !v_s1_q && !v_s2_q && div_cnt_q == '0, "request started with work in flight")
	`SSIS_ASSERT_HOLDS(a_out_load_ok, cmd.out_load, div_cnt_q == '0 && !(out_valid_q && out_stall), "result loaded before divide end or into a held result")
	`SSIS_ASSERT_NEXT(a_grid_wraps, cmd.issue && status.last_sample, j_q == '0, "column counter not rewound after final sample")

endmodule

FILE: hw/rtl/supersample_image_scaler_core.sv
// Top level of the supersampling box-filter image scaler.
// Load: written to the image memory at the accepting edge, no result.
// Request: result valid after the sample sweep and the bit-serial divide of the SW-bit sums
// (SW = sum width, 14 for N up to 8); the single memory read port takes one sample per cycle.
// A new item is accepted in the cycle after a result is loaded into the output register.
// Reset: asynchronous; registers return to their defaults, image memory is undefined until loaded.
module supersample_image_scaler_core #(
	parameter int unsigned MAX_SRC_WIDTH  = ssis_pkg::DEF_MAX_SRC_WIDTH,
	parameter int unsigned MAX_SRC_HEIGHT = ssis_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int unsigned MAX_SAMPLES    = ssis_pkg::DEF_MAX_SAMPLES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [ssis_pkg::COORD_W-1:0]    load_x,
	input  logic [ssis_pkg::COORD_W-1:0]    load_y,
	input  logic [ssis_pkg::COLOR_W-1:0]    load_red,
	input  logic [ssis_pkg::COLOR_W-1:0]    load_green,
	input  logic [ssis_pkg::COLOR_W-1:0]    load_blue,
	input  logic [ssis_pkg::DEST_W-1:0]     dest_u,
	input  logic [ssis_pkg::DEST_W-1:0]     dest_v,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ssis_pkg::COLOR_W-1:0]    out_red,
	output logic [ssis_pkg::COLOR_W-1:0]    out_green,
	output logic [ssis_pkg::COLOR_W-1:0]    out_blue,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssis_pkg::*;

	ssis_cmd_t    cmd;
	ssis_status_t status;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	ssis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ssis_datapath #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
		.MAX_SAMPLES    (MAX_SAMPLES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_red   (load_red),
		.load_green (load_green),
		.load_blue  (load_blue),
		.dest_u     (dest_u),
		.dest_v     (dest_v),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue)
	);

endmodule

FILE: tb/supersample_image_scaler_core_test.sv
// Self-checking testbench for the supersampling image scaler core.
module supersample_image_scaler_core_test;
	import ssis_pkg::*;

	localparam int unsigned IMG_W       = DEF_MAX_SRC_WIDTH;
	localparam int unsigned IMG_H       = DEF_MAX_SRC_HEIGHT;
	localparam int unsigned IMG_DEPTH   = IMG_W * IMG_H;
	localparam int unsigned MAX_SAMP    = DEF_MAX_SAMPLES;
	localparam int unsigned SETTLE      = 100;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_ITEMS = 155;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic                op;
		logic [COORD_W-1:0]  load_x;
		logic [COORD_W-1:0]  load_y;
		logic [COLOR_W-1:0]  load_red;
		logic [COLOR_W-1:0]  load_green;
		logic [COLOR_W-1:0]  load_blue;
		logic [DEST_W-1:0]   dest_u;
		logic [DEST_W-1:0]   dest_v;
	} scaler_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

	// Mirror of the source image and registers; averages the sample grid per scale request
	class grid_average_tracker;
		logic [3*COLOR_W-1:0] image [IMG_DEPTH];
		bit                   loaded [IMG_DEPTH];
		logic [DIM_W-1:0]     width_reg, height_reg;
		logic [SAMP_W-1:0]    samples_reg;
		logic [STEP_W-1:0]    step_x_reg, step_y_reg, substep_x_reg, substep_y_reg;
		pixel_t               pending_pixels [$];
		int unsigned          errors;

		function new();
			width_reg     = RST_SRC_WIDTH;
			height_reg    = RST_SRC_HEIGHT;
			samples_reg   = RST_SAMPLES;
			step_x_reg    = RST_STEP;
			step_y_reg    = RST_STEP;
			substep_x_reg = RST_SUBSTEP;
			substep_y_reg = RST_SUBSTEP;
			errors        = 0;
		endfunction

		// Zero reads as one, oversize saturates
		function int unsigned clamp_dim(int unsigned value, int unsigned hi);
			if (value == 0)
				return 1;
			if (value > hi)
				return hi;
			return value;
		endfunction

		function int unsigned grid_size();
			return clamp_dim(samples_reg, MAX_SAMP);
		endfunction

		// Integer part of coord*step + k*substep, clamped to the last column or row
		function int unsigned grid_index(logic [DEST_W-1:0] coord, logic [STEP_W-1:0] step,
				logic [STEP_W-1:0] substep, int unsigned k, int unsigned limit);
			longint unsigned pos;
			pos = 64'(coord) * 64'(step) + 64'(substep) * 64'(k);
			pos = pos >> FRAC_BITS;
			if (pos >= limit)
				pos = limit - 1;
			return int'(pos);
		endfunction

		function int unsigned sample_addr(logic [DEST_W-1:0] u, logic [DEST_W-1:0] v,
				int unsigned i, int unsigned j);
			int unsigned row, col;
			row = grid_index(v, step_y_reg, substep_y_reg, i, clamp_dim(height_reg, IMG_H));
			col = grid_index(u, step_x_reg, substep_x_reg, j, clamp_dim(width_reg, IMG_W));
			return row * IMG_W + col;
		endfunction

		function pixel_t average_grid(logic [DEST_W-1:0] u, logic [DEST_W-1:0] v);
			int unsigned n, a, r, g, b;
			pixel_t px;
			n = grid_size();
			r = 0;
			g = 0;
			b = 0;
			for (int unsigned i = 0; i < n; i++) begin
				for (int unsigned j = 0; j < n; j++) begin
					a = sample_addr(u, v, i, j);
					r += image[a][23:16];
					g += image[a][15:8];
					b += image[a][7:0];
				end
			end
			px.red   = COLOR_W'(r / (n * n));
			px.green = COLOR_W'(g / (n * n));
			px.blue  = COLOR_W'(b / (n * n));
			return px;
		endfunction

		// Entries the grid would touch that hold nothing yet, each listed once
		function void missing_samples(logic [DEST_W-1:0] u, logic [DEST_W-1:0] v,
				output int unsigned addrs [$]);
			bit seen [int unsigned];
			int unsigned n, a;
			addrs = {};
			n = grid_size();
			for (int unsigned i = 0; i < n; i++) begin
				for (int unsigned j = 0; j < n; j++) begin
					a = sample_addr(u, v, i, j);
					if (!loaded[a] && !seen.exists(a)) begin
						seen[a] = 1'b1;
						addrs.push_back(a);
					end
				end
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SRC_WIDTH:  width_reg     = data[DIM_W-1:0];
				REG_SRC_HEIGHT: height_reg    = data[DIM_W-1:0];
				REG_SAMPLES:    samples_reg   = data[SAMP_W-1:0];
				REG_STEP_X:     step_x_reg    = data[STEP_W-1:0];
				REG_STEP_Y:     step_y_reg    = data[STEP_W-1:0];
				REG_SUBSTEP_X:  substep_x_reg = data[STEP_W-1:0];
				REG_SUBSTEP_Y:  substep_y_reg = data[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(scaler_item_t it);
			int unsigned a;
			if (it.op == OP_LOAD) begin
				a = 32'(it.load_y) * IMG_W + 32'(it.load_x);
				image[a]  = {it.load_red, it.load_green, it.load_blue};
				loaded[a] = 1'b1;
			end else begin
				pending_pixels.push_back(average_grid(it.dest_u, it.dest_v));
			end
		endfunction

		function void compare_field(string name, logic [COLOR_W-1:0] want,
				logic [COLOR_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %0d/%0d/%0d", $time, got.red, got.green,
					got.blue);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			compare_field("out_red", want.red, got.red);
			compare_field("out_green", want.green, got.green);
			compare_field("out_blue", want.blue, got.blue);
		endfunction

		function int unsigned pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [COORD_W-1:0]    load_x, load_y;
	logic [COLOR_W-1:0]    load_red, load_green, load_blue;
	logic [DEST_W-1:0]     dest_u, dest_v;
	logic                  out_valid;
	logic                  out_stall;
	logic [COLOR_W-1:0]    out_red, out_green, out_blue;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grid_average_tracker tracker = new();
	scaler_item_t        in_seen;
	pixel_t              out_seen;
	int unsigned         items_sent = 0;
	int                  hold_left = 0;
	bit                  gaps_on = 1'b1;

	assign in_seen  = {op, load_x, load_y, load_red, load_green, load_blue, dest_u, dest_v};
	assign out_seen = {out_red, out_green, out_blue};

	supersample_image_scaler_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.load_x     (load_x),
		.load_y     (load_y),
		.load_red   (load_red),
		.load_green (load_green),
		.load_blue  (load_blue),
		.dest_u     (dest_u),
		.dest_v     (dest_v),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Track accepted input items and accepted output pixels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_item(in_seen);
			if (out_valid && !out_stall)
				tracker.check_pixel(out_seen);
		end
	end

	// Output side: random stalls, or a long hold-off when asked
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= gaps_on && ($urandom_range(99) < 17);
			end
		end
	end

	// Give up when nothing moves on any channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("supersample_image_scaler_core_test failed");
		$finish;
	end

	// Offer one request; returns at the falling edge after it was taken
	task automatic push_item(input scaler_item_t it);
		while (gaps_on && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= it.op;
		load_x     <= it.load_x;
		load_y     <= it.load_y;
		load_red   <= it.load_red;
		load_green <= it.load_green;
		load_blue  <= it.load_blue;
		dest_u     <= it.dest_u;
		dest_v     <= it.dest_v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		scaler_item_t it;
		it.op         = OP_LOAD;
		it.load_x     = x;
		it.load_y     = y;
		it.load_red   = r;
		it.load_green = g;
		it.load_blue  = b;
		it.dest_u     = DEST_W'($urandom);
		it.dest_v     = DEST_W'($urandom);
		push_item(it);
	endtask

	// Scale request; first fills any grid entry still empty with random colour
	task automatic request_pixel(input logic [DEST_W-1:0] u, input logic [DEST_W-1:0] v);
		int unsigned  addrs [$];
		scaler_item_t it;
		tracker.missing_samples(u, v, addrs);
		foreach (addrs[k])
			load_pixel(COORD_W'(addrs[k] % IMG_W), COORD_W'(addrs[k] / IMG_W),
				COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		it.op         = OP_REQUEST;
		it.load_x     = COORD_W'($urandom);
		it.load_y     = COORD_W'($urandom);
		it.load_red   = COLOR_W'($urandom);
		it.load_green = COLOR_W'($urandom);
		it.load_blue  = COLOR_W'($urandom);
		it.dest_u     = u;
		it.dest_v     = v;
		push_item(it);
	endtask

	// Half inside the configured image, half anywhere in the store
	task automatic random_load();
		int unsigned  w, h;
		logic [COORD_W-1:0] x, y;
		w = tracker.clamp_dim(tracker.width_reg, IMG_W);
		h = tracker.clamp_dim(tracker.height_reg, IMG_H);
		if ($urandom_range(1)) begin
			x = COORD_W'($urandom_range(0, w - 1));
			y = COORD_W'($urandom_range(0, h - 1));
		end else begin
			x = COORD_W'($urandom);
			y = COORD_W'($urandom);
		end
		load_pixel(x, y, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
	endtask

	// Mostly coordinates that land inside the image, some anywhere
	function automatic logic [DEST_W-1:0] pick_coord(int unsigned dim, logic [STEP_W-1:0] step);
		longint unsigned lim;
		if (step == 0 || $urandom_range(99) < 20)
			return DEST_W'($urandom);
		lim = (64'(dim) << FRAC_BITS) / 64'(step);
		if (lim > 4095)
			lim = 4095;
		return DEST_W'($urandom_range(0, int'(lim)));
	endfunction

	task automatic random_traffic(input int unsigned count);
		int unsigned stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			if ($urandom_range(99) < 30)
				random_load();
			else
				request_pixel(
					pick_coord(tracker.clamp_dim(tracker.width_reg, IMG_W), tracker.step_x_reg),
					pick_coord(tracker.clamp_dim(tracker.height_reg, IMG_H), tracker.step_y_reg));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Reprogram only once the block has drained and settled
	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] n, input logic [CFG_DATA_W-1:0] sx,
			input logic [CFG_DATA_W-1:0] sy, input logic [CFG_DATA_W-1:0] bx,
			input logic [CFG_DATA_W-1:0] by, input bit poke_unused);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_SAMPLES, n);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_SUBSTEP_X, bx);
		write_reg(REG_SUBSTEP_Y, by);
		if (poke_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Junk above bit 8 now and then; the block keeps only the low bits
	function automatic logic [CFG_DATA_W-1:0] rand_dim();
		logic [CFG_DATA_W-1:0] d;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: d = CFG_DATA_W'($urandom_range(1, 16));
			5, 6, 7:       d = CFG_DATA_W'($urandom_range(1, 256));
			default:       d = CFG_DATA_W'($urandom_range(0, 511));
		endcase
		if ($urandom_range(99) < 30)
			d |= CFG_DATA_W'($urandom) & 25'h1FFFE00;
		return d;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_samples();
		logic [CFG_DATA_W-1:0] d;
		if ($urandom_range(99) < 70)
			d = CFG_DATA_W'($urandom_range(1, 4));
		else
			d = CFG_DATA_W'($urandom_range(0, 15));
		if ($urandom_range(99) < 30)
			d |= CFG_DATA_W'($urandom) & 25'h1FFFFF0;
		return d;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_step();
		case ($urandom_range(5))
			0:       return '0;
			1, 2:    return CFG_DATA_W'($urandom_range(0, 32'h3FFFF));
			3, 4:    return CFG_DATA_W'($urandom_range(32'h8000, 32'h20000));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_substep();
		if ($urandom_range(99) < 80)
			return CFG_DATA_W'($urandom_range(0, 32'h1FFFF));
		return CFG_DATA_W'($urandom);
	endfunction

	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = OP_LOAD;
		load_x     = '0;
		load_y     = '0;
		load_red   = '0;
		load_green = '0;
		load_blue  = '0;
		dest_u     = '0;
		dest_v     = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: corner pixels, colour extremes, far corners of the output
		load_pixel(8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
		load_pixel(8'd255, 8'd255, 8'h00, 8'hFF, 8'h00);
		load_pixel(8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		load_pixel(8'd0, 8'd255, 8'h00, 8'h00, 8'h00);
		request_pixel(12'd0, 12'd0);
		request_pixel(12'd4095, 12'd4095);
		request_pixel(12'd4095, 12'd0);
		request_pixel(12'd0, 12'd4095);
		request_pixel(12'd255, 12'd255);

		// Zero size and zero sample count read as one; unused index ignored
		configure(25'd0, 25'd0, 25'd0, 25'h18000, 25'h0C000, 25'h04000, 25'h08000, 1'b1);
		load_pixel(8'd200, 8'd100, 8'h5A, 8'hA5, 8'h3C);
		request_pixel(12'd0, 12'd0);
		request_pixel(12'd4095, 12'd4095);

		// Oversize dimensions and sample count saturate; widest steps
		configure(25'd511, 25'd300, 25'd15, 25'h1FFFFFF, 25'h1000000, 25'h1000000, 25'd0, 1'b0);
		request_pixel(12'd0, 12'd0);
		request_pixel(12'd1, 12'd1);
		request_pixel(12'd4095, 12'd4095);

		// Zero steps: every destination pixel maps to the same grid
		configure(25'd256, 25'd256, 25'd8, 25'd0, 25'd0, 25'h1FFFFFF, 25'h02000, 1'b0);
		request_pixel(12'd0, 12'd0);
		request_pixel(12'd4095, 12'd4095);

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: configure(25'd256, 25'd256, 25'd8, 25'h1000000, 25'h1000000,
					25'h1000000, 25'h1000000, 1'b0);
				3: configure(25'd1, 25'd1, 25'd1, 25'd0, 25'd0, 25'd0, 25'd0, 1'b1);
				default: configure(rand_dim(), rand_dim(), rand_samples(), rand_step(),
					rand_step(), rand_substep(), rand_substep(), $urandom_range(1));
			endcase
			gaps_on = (p != 2);
			if (p == 1) begin
				random_traffic(70);
				// Output held off while requests keep coming, so the input backs up
				hold_left = HOLD_CYCLES;
				random_traffic(40);
				// Let every scaled pixel come home before going on
				in_valid <= 1'b0;
				do @(negedge clk); while (tracker.pending() != 0);
				random_traffic(PHASE_ITEMS - 110);
			end else begin
				random_traffic(PHASE_ITEMS);
			end
		end
		gaps_on = 1'b1;

		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (tracker.errors == 0)
			$display("supersample_image_scaler_core_test passed");
		else
			$display("supersample_image_scaler_core_test failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ssis_pkg.sv
hw/rtl/ssis_ctrl.sv
hw/rtl/ssis_datapath.sv
hw/rtl/supersample_image_scaler_core.sv
tb/supersample_image_scaler_core_test.sv
